// ===== src/tws_pkg.sv =====
// ============================================================================
// tws_pkg - shared types and constants for the temperature window statistics
// Widths, reset values, register indexes, result codes and the job record
// passed from the front end to the back end through the job queue.
// ============================================================================
package tws_pkg;

    // Window and sample geometry
    localparam int WINDOW_DEPTH = 10;
    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_W      = 16;
    localparam int MARGIN_W     = 15;
    localparam int COUNT_W      = 32;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = SAMPLE_W + FILL_W;
    localparam int RSUM_W       = SAMPLE_W + 2;
    localparam int WIDE_W       = (SAMPLE_W > LEVEL_W) ? SAMPLE_W : LEVEL_W;
    localparam int CMP_W        = ((WIDE_W > MARGIN_W) ? WIDE_W : MARGIN_W + 1) + 6;

    // Trend needs this many readings; it looks back this many older ones
    localparam int TREND_MIN_FILL = 3;
    localparam int TREND_OLD_MAX  = 3;

    // Divider: two quotient bits per cycle
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int REM_W     = FILL_W + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [LEVEL_W-1:0]  t_level;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam t_level                WARN_LOW_RST  = LEVEL_W'(1000);
    localparam t_level                WARN_HIGH_RST = LEVEL_W'(3500);
    localparam logic [MARGIN_W-1:0]   MARGIN_RST    = MARGIN_W'(50);

    typedef enum logic [1:0] {
        REG_WARN_LOW  = 2'd0,
        REG_WARN_HIGH = 2'd1,
        REG_MARGIN    = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        TREND_INSUFF  = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2,
        TREND_STABLE  = 2'd3
    } t_trend;

    typedef enum logic [1:0] {
        WARN_NONE = 2'd0,
        WARN_LOW  = 2'd1,
        WARN_HIGH = 2'd2
    } t_warn;

    // One classified reading, ready for the back end
    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic [FILL_W-1:0]        fill;
        logic                     trend_ok;
        logic signed [RSUM_W-1:0] rsum;
        logic signed [RSUM_W-1:0] osum;
        logic [1:0]               n_old;
        t_sample                  lo;
        t_sample                  hi;
        t_warn                    warn;
        logic [COUNT_W-1:0]       count;
    } t_job;

endpackage

// ===== src/tws_in_if.sv =====
// ============================================================================
// tws_in_if - sample channel
// Valid/ready channel carrying one temperature sample and its invalid flag.
// ============================================================================
interface tws_in_if;
    logic                   valid;
    logic                   ready;
    tws_pkg::t_sample       temperature;
    logic                   sample_invalid;

    modport source (output valid, output temperature, output sample_invalid, input ready);
    modport sink   (input valid, input temperature, input sample_invalid, output ready);
endinterface

// ===== src/tws_out_if.sv =====
// ============================================================================
// tws_out_if - statistics result channel
// Valid/ready channel carrying one set of window statistics.
// ============================================================================
interface tws_out_if;
    logic                          valid;
    logic                          ready;
    tws_pkg::t_sample              window_average;
    tws_pkg::t_sample              lowest_seen;
    tws_pkg::t_sample              highest_seen;
    logic [1:0]                    trend_code;
    logic [1:0]                    warning_code;
    logic [tws_pkg::COUNT_W-1:0]   readings_taken;
    logic [tws_pkg::FILL_W-1:0]    window_fill;

    modport source (output valid, output window_average, output lowest_seen,
                    output highest_seen, output trend_code, output warning_code,
                    output readings_taken, output window_fill, input ready);
    modport sink   (input valid, input window_average, input lowest_seen,
                    input highest_seen, input trend_code, input warning_code,
                    input readings_taken, input window_fill, output ready);
endinterface

// ===== src/tws_front.sv =====
// ============================================================================
// tws_front - sample intake and window bookkeeping
// Accepts samples, drops invalid ones, shifts valid ones into the window,
// keeps the running sum, extremes and count, and emits one job per reading.
// ============================================================================
module tws_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tws_in_if.sink               i_sample,
    input  tws_pkg::t_level      i_warn_low,
    input  tws_pkg::t_level      i_warn_high,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output tws_pkg::t_job        o_job
);

    tws_pkg::t_sample                  r_win [tws_pkg::WINDOW_DEPTH];
    logic [tws_pkg::FILL_W-1:0]        r_fill;
    logic signed [tws_pkg::SUM_W-1:0]  r_sum;
    tws_pkg::t_sample                  r_min;
    tws_pkg::t_sample                  r_max;
    logic [tws_pkg::COUNT_W-1:0]       r_count;

    logic [tws_pkg::FILL_W-1:0]        n_fill;
    logic signed [tws_pkg::SUM_W-1:0]  n_sum;
    tws_pkg::t_sample                  n_min;
    tws_pkg::t_sample                  n_max;
    logic [tws_pkg::COUNT_W-1:0]       n_count;

    tws_pkg::t_sample                  t;
    logic                              full;
    logic signed [tws_pkg::SUM_W-1:0]  evict;

    // Take a sample whenever the job queue has room
    assign i_sample.ready = !i_queue_full;
    assign o_push         = i_sample.valid && !i_queue_full && !i_sample.sample_invalid;
    assign t              = i_sample.temperature;

    // Next window bookkeeping
    assign full    = (r_fill == tws_pkg::FILL_W'(tws_pkg::WINDOW_DEPTH));
    assign n_fill  = full ? r_fill : r_fill + tws_pkg::FILL_W'(1);
    assign evict   = full ? tws_pkg::SUM_W'(r_win[tws_pkg::WINDOW_DEPTH-1])
                          : '0;
    assign n_sum   = r_sum + tws_pkg::SUM_W'(t) - evict;
    assign n_min   = (t < r_min) ? t : r_min;
    assign n_max   = (t > r_max) ? t : r_max;
    assign n_count = r_count + tws_pkg::COUNT_W'(1);

    // Build the job from the state as it stands after this reading
    always_comb begin
        logic signed [tws_pkg::CMP_W-1:0]  t_x;
        logic signed [tws_pkg::CMP_W-1:0]  low_x;
        logic signed [tws_pkg::CMP_W-1:0]  high_x;
        logic [tws_pkg::FILL_W-1:0]        older;
        logic [1:0]                        n_old;
        logic signed [tws_pkg::RSUM_W-1:0] osum;

        t_x    = tws_pkg::CMP_W'(t);
        low_x  = tws_pkg::CMP_W'(i_warn_low);
        high_x = tws_pkg::CMP_W'(i_warn_high);

        // Older readings: those beyond the newest three, at most three
        older = n_fill - tws_pkg::FILL_W'(tws_pkg::TREND_MIN_FILL);
        if (n_fill >= tws_pkg::FILL_W'(tws_pkg::TREND_MIN_FILL + tws_pkg::TREND_OLD_MAX)) begin
            n_old = 2'(tws_pkg::TREND_OLD_MAX);
        end else if (n_fill >= tws_pkg::FILL_W'(tws_pkg::TREND_MIN_FILL)) begin
            n_old = older[1:0];
        end else begin
            n_old = 2'd0;
        end

        // After the shift, newest is t, then r_win[0], r_win[1], ...
        osum = '0;
        if (n_old >= 2'd1) begin
            osum = osum + tws_pkg::RSUM_W'(r_win[2]);
        end
        if (n_old >= 2'd2) begin
            osum = osum + tws_pkg::RSUM_W'(r_win[3]);
        end
        if (n_old >= 2'd3) begin
            osum = osum + tws_pkg::RSUM_W'(r_win[4]);
        end

        o_job.sum      = n_sum;
        o_job.fill     = n_fill;
        o_job.trend_ok = (n_fill >= tws_pkg::FILL_W'(tws_pkg::TREND_MIN_FILL));
        o_job.rsum     = tws_pkg::RSUM_W'(t) + tws_pkg::RSUM_W'(r_win[0])
                       + tws_pkg::RSUM_W'(r_win[1]);
        o_job.osum     = osum;
        o_job.n_old    = n_old;
        o_job.lo       = n_min;
        o_job.hi       = n_max;
        o_job.count    = n_count;

        // Low warning wins over high
        if (t_x < low_x) begin
            o_job.warn = tws_pkg::WARN_LOW;
        end else if (t_x > high_x) begin
            o_job.warn = tws_pkg::WARN_HIGH;
        end else begin
            o_job.warn = tws_pkg::WARN_NONE;
        end
    end

    // Hold running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_sum   <= '0;
            r_min   <= tws_pkg::SAMPLE_MAX;
            r_max   <= tws_pkg::SAMPLE_MIN;
            r_count <= '0;
        end else if (o_push) begin
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_min   <= n_min;
            r_max   <= n_max;
            r_count <= n_count;
        end
    end

    // Shift the reading window, newest at the head
    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_win[0] <= t;
            for (int k = 1; k < tws_pkg::WINDOW_DEPTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

endmodule

// ===== src/tws_queue.sv =====
// ============================================================================
// tws_queue - job queue between front and back end
// Small first-in first-out store of classified readings.
// ============================================================================
module tws_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tws_pkg::t_job   i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tws_pkg::t_job   o_job
);

    tws_pkg::t_job                r_mem [tws_pkg::QUEUE_DEPTH];
    logic [tws_pkg::QPTR_W-1:0]   r_wr;
    logic [tws_pkg::QPTR_W-1:0]   r_rd;
    logic [tws_pkg::QCNT_W-1:0]   r_cnt;

    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == tws_pkg::QCNT_W'(tws_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == tws_pkg::QPTR_W'(tws_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr + tws_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == tws_pkg::QPTR_W'(tws_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd + tws_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + tws_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - tws_pkg::QCNT_W'(1);
            end
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/tws_back.sv =====
// ============================================================================
// tws_back - trend decision, average divider and result register
// Pops one job, decides the trend, divides the window sum by the fill two
// quotient bits per cycle, and holds the finished result for the sink.
// ============================================================================
module tws_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tws_pkg::MARGIN_W-1:0]   i_margin,
    input  logic                           i_q_valid,
    input  tws_pkg::t_job                  i_job,
    output logic                           o_pop,
    tws_out_if.source                      o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                          r_state;
    logic [tws_pkg::DIV_W-1:0]       r_dvd;
    logic [tws_pkg::REM_W-1:0]       r_rem;
    logic [tws_pkg::STEP_W-1:0]      r_step;
    logic                            r_neg;
    logic [tws_pkg::FILL_W-1:0]      r_fill;
    tws_pkg::t_sample                r_lo;
    tws_pkg::t_sample                r_hi;
    tws_pkg::t_warn                  r_warn;
    tws_pkg::t_trend                 r_trend;
    logic [tws_pkg::COUNT_W-1:0]     r_count;
    logic                            r_out_valid;
    tws_pkg::t_sample                r_o_avg;
    tws_pkg::t_sample                r_o_lo;
    tws_pkg::t_sample                r_o_hi;
    tws_pkg::t_trend                 r_o_trend;
    tws_pkg::t_warn                  r_o_warn;
    logic [tws_pkg::COUNT_W-1:0]     r_o_count;
    logic [tws_pkg::FILL_W-1:0]      r_o_fill;

    logic [tws_pkg::DIV_W-1:0]       n_dvd;
    logic [tws_pkg::REM_W-1:0]       n_rem;
    tws_pkg::t_trend                 n_trend;
    logic [tws_pkg::SUM_W-1:0]       n_mag;
    tws_pkg::t_sample                n_avg;
    logic                            take;
    logic                            load_out;

    assign take     = r_out_valid && o_result.ready;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || take);
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;

    // Decide the trend by cross-multiplied sums
    always_comb begin
        logic signed [tws_pkg::CMP_W-1:0] rsum_x;
        logic signed [tws_pkg::CMP_W-1:0] osum_x;
        logic signed [tws_pkg::CMP_W-1:0] m_x;
        logic signed [tws_pkg::CMP_W-1:0] m3;
        logic signed [tws_pkg::CMP_W-1:0] lhs;
        logic signed [tws_pkg::CMP_W-1:0] rhs3;
        logic signed [tws_pkg::CMP_W-1:0] mg;

        rsum_x = tws_pkg::CMP_W'(i_job.rsum);
        osum_x = tws_pkg::CMP_W'(i_job.osum);
        m_x    = tws_pkg::CMP_W'(i_margin);
        m3     = m_x + (m_x <<< 1);
        rhs3   = osum_x + (osum_x <<< 1);

        // No older readings weighs like one: older average is zero
        case (i_job.n_old)
            2'd2: begin
                lhs = rsum_x <<< 1;
                mg  = m3 <<< 1;
            end
            2'd3: begin
                lhs = rsum_x + (rsum_x <<< 1);
                mg  = (m_x <<< 3) + m_x;
            end
            default: begin
                lhs = rsum_x;
                mg  = m3;
            end
        endcase

        if (!i_job.trend_ok) begin
            n_trend = tws_pkg::TREND_INSUFF;
        end else if (lhs > rhs3 + mg) begin
            n_trend = tws_pkg::TREND_RISING;
        end else if (lhs < rhs3 - mg) begin
            n_trend = tws_pkg::TREND_FALLING;
        end else begin
            n_trend = tws_pkg::TREND_STABLE;
        end
    end

    // Magnitude of the window sum for the divider
    always_comb begin
        if (i_job.sum[tws_pkg::SUM_W-1]) begin
            n_mag = -i_job.sum;
        end else begin
            n_mag = i_job.sum;
        end
    end

    // Two restoring division steps per cycle
    always_comb begin
        logic [tws_pkg::REM_W-1:0] rem_a;
        logic [tws_pkg::REM_W-1:0] rem_b;
        logic [tws_pkg::REM_W-1:0] rem_m;
        logic [tws_pkg::DIV_W-1:0] dvd_m;
        logic [tws_pkg::REM_W-1:0] div_x;
        logic                      ge_a;
        logic                      ge_b;

        div_x = {1'b0, r_fill};

        rem_a = {r_rem[tws_pkg::REM_W-2:0], r_dvd[tws_pkg::DIV_W-1]};
        ge_a  = (rem_a >= div_x);
        rem_m = ge_a ? rem_a - div_x : rem_a;
        dvd_m = {r_dvd[tws_pkg::DIV_W-2:0], ge_a};

        rem_b = {rem_m[tws_pkg::REM_W-2:0], dvd_m[tws_pkg::DIV_W-1]};
        ge_b  = (rem_b >= div_x);
        n_rem = ge_b ? rem_b - div_x : rem_b;
        n_dvd = {dvd_m[tws_pkg::DIV_W-2:0], ge_b};
    end

    // Apply the sign: quotient truncates toward zero
    always_comb begin
        logic [tws_pkg::DIV_W-1:0] q_s;

        q_s   = r_neg ? (~r_dvd + tws_pkg::DIV_W'(1)) : r_dvd;
        n_avg = q_s[tws_pkg::SAMPLE_W-1:0];
    end

    // Sequence one job: load, divide, hand over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Fill the result register on hand-over, empty it when taken
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_dvd   <= tws_pkg::DIV_W'(n_mag);
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_neg   <= i_job.sum[tws_pkg::SUM_W-1];
                        r_fill  <= i_job.fill;
                        r_lo    <= i_job.lo;
                        r_hi    <= i_job.hi;
                        r_warn  <= i_job.warn;
                        r_trend <= n_trend;
                        r_count <= i_job.count;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_dvd  <= n_dvd;
                    r_rem  <= n_rem;
                    r_step <= r_step + tws_pkg::STEP_W'(1);
                    if (r_step == tws_pkg::STEP_W'(tws_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_o_avg     <= n_avg;
                        r_o_lo      <= r_lo;
                        r_o_hi      <= r_hi;
                        r_o_trend   <= r_trend;
                        r_o_warn    <= r_warn;
                        r_o_count   <= r_count;
                        r_o_fill    <= r_fill;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the result channel
    assign o_result.valid          = r_out_valid;
    assign o_result.window_average = r_o_avg;
    assign o_result.lowest_seen    = r_o_lo;
    assign o_result.highest_seen   = r_o_hi;
    assign o_result.trend_code     = r_o_trend;
    assign o_result.warning_code   = r_o_warn;
    assign o_result.readings_taken = r_o_count;
    assign o_result.window_fill    = r_o_fill;

endmodule

// ===== src/temperature_window_stats_core.sv =====
// ============================================================================
// temperature_window_stats_core - windowed temperature statistics
// Moving average, running extremes, trend and warnings over valid samples.
// ============================================================================
//
//  Channel    Dir  Handshake             Beat
//  i_sample   in   valid/ready           temperature, sample_invalid
//  o_result   out  valid/ready           average, extremes, codes, count, fill
//  APB        in   psel/penable/pready   warn_low_level, warn_high_level,
//                                        trend_margin at 0x0, 0x4, 0x8
//
//  A sample beat is taken while the two-entry job queue has room;
//  an invalid sample is dropped there and gives no result.
//  Per reading the back end pops a job and decides the trend, divides the 20-bit
//  window sum in the two-bit-per-cycle divider, then loads the output register
//  once that is free; it pops no further job until the result is loaded.
//  Synchronous active-low reset clears statistics and restores register
//  defaults; the result register holds a beat until the sink takes it.
//
module temperature_window_stats_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tws_in_if.sink                             i_sample,
    tws_out_if.source                          o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tws_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [tws_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tws_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    tws_pkg::t_level                  r_warn_low;
    tws_pkg::t_level                  r_warn_high;
    logic [tws_pkg::MARGIN_W-1:0]     r_margin;

    logic                             cfg_wr;
    logic [1:0]                       reg_idx;
    logic                             push;
    logic                             queue_full;
    tws_pkg::t_job                    front_job;
    logic                             q_valid;
    tws_pkg::t_job                    q_job;
    logic                             pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[tws_pkg::REG_ADDR_W-1:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_low  <= tws_pkg::WARN_LOW_RST;
            r_warn_high <= tws_pkg::WARN_HIGH_RST;
            r_margin    <= tws_pkg::MARGIN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                tws_pkg::REG_WARN_LOW:  r_warn_low  <= pwdata[tws_pkg::LEVEL_W-1:0];
                tws_pkg::REG_WARN_HIGH: r_warn_high <= pwdata[tws_pkg::LEVEL_W-1:0];
                tws_pkg::REG_MARGIN:    r_margin    <= pwdata[tws_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_idx)
            tws_pkg::REG_WARN_LOW:
                prdata = tws_pkg::APB_DATA_W'($unsigned(r_warn_low));
            tws_pkg::REG_WARN_HIGH:
                prdata = tws_pkg::APB_DATA_W'($unsigned(r_warn_high));
            tws_pkg::REG_MARGIN:
                prdata = tws_pkg::APB_DATA_W'(r_margin);
            default:
                prdata = '0;
        endcase
    end

    tws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_warn_low   (r_warn_low),
        .i_warn_high  (r_warn_high),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    tws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    tws_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_margin  (r_margin),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .o_result  (o_result)
    );

    // Fill of a delivered beat is within the window
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.window_fill != '0 &&
            o_result.window_fill <= tws_pkg::FILL_W'(tws_pkg::WINDOW_DEPTH)))
        else $error("window fill out of range");

    // Extremes are ordered once any reading is in
    a_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.lowest_seen <= o_result.highest_seen))
        else $error("lowest above highest");

    // The average lies between the extremes seen so far
    a_avg_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.window_average >= o_result.lowest_seen &&
            o_result.window_average <= o_result.highest_seen))
        else $error("window average outside extremes");

    // Trend is insufficient exactly while the window is short
    a_trend_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.trend_code == tws_pkg::TREND_INSUFF) ==
            (o_result.window_fill < tws_pkg::FILL_W'(tws_pkg::TREND_MIN_FILL))))
        else $error("trend code disagrees with window fill");

endmodule
